// ===== src/asrl_pkg.sv =====
// ----------------------------------------------------------------------------
// asrl_pkg
// Shared types and codes of the asymmetric slew-rate limiter.
// ----------------------------------------------------------------------------
package asrl_pkg;

  localparam int RATE_W = 32;
  localparam int STEP_W = 32;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_RANGE  = 2'd1;
  localparam status_t ST_NOINIT = 2'd2;

  typedef logic cfg_index_t;

  localparam cfg_index_t CFG_RISING  = 1'b0;
  localparam cfg_index_t CFG_FALLING = 1'b1;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

endpackage

// ===== src/asymmetric_slew_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// asymmetric_slew_rate_limiter_core
// Moves a held value toward each requested target, limited by separate
// rising and falling rates, and reports the applied rate.
// ----------------------------------------------------------------------------
// Channels: in_* takes one word per request (tuser = reset flag, tdata =
// target then time step); out_* gives one word per request (status, new
// value, applied rate); cfg_* writes the rising (index 0) and falling
// (index 1) rate registers and is always ready.
// Sequence: a reset request or a rejected step goes from acceptance to the
// finish state, which loads the output register. A limited step passes
// through a multiply step and a limit step, then one quotient bit per cycle
// from a restoring subtract/compare unit, then a check step and the finish
// state, which loads the output register.
// Throughput: one request at a time; in_tready is low from acceptance
// until the result is loaded into the output register.
// Stall: the output register holds its word while out_tready is low, and
// a finished result waits in the sequencer until the register is free.
// Reset: clears both rates, the held value and the initialized flag, and
// drops out_tvalid.
// ----------------------------------------------------------------------------
module asymmetric_slew_rate_limiter_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_W  = ((VALUE_WIDTH + asrl_pkg::STEP_W) + 7) / 8 * 8,
  localparam int OUT_W = ((2 + 2 * VALUE_WIDTH) + 7) / 8 * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_W-1:0]             in_tdata,   // target_value, time_step
  input  logic                        in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata,  // status, new value, applied rate
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  asrl_pkg::cfg_index_t        cfg_index,
  input  logic [asrl_pkg::RATE_W-1:0] cfg_data
);
  import asrl_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int AW   = VW + 1;
  localparam int QW   = AW + FRAC_BITS;
  localparam int CW   = (AW > 64) ? AW : 64;
  localparam int CNTW = $clog2(QW + 1);
  localparam int PW   = RATE_W + STEP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LIM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_r;
  logic [RATE_W-1:0] rising_r;
  logic [RATE_W-1:0] falling_r;
  logic [VW-1:0]     held_r;
  logic              init_r;
  logic [VW-1:0]     tgt_r;
  logic [STEP_W-1:0] dt_r;
  logic              up_r;
  logic [AW-1:0]     mag_r;
  logic [PW-1:0]     prod_r;
  logic [AW-1:0]     appl_r;
  logic [QW-1:0]     div_r;
  logic [STEP_W-1:0] rem_r;
  logic [CNTW-1:0]   cnt_r;
  status_t           res_status_r;
  logic [VW-1:0]     res_value_r;
  logic [VW-1:0]     res_rate_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [VW-1:0]     in_target;
  logic [STEP_W-1:0] in_step;
  logic              in_fire;
  logic              up_c;
  logic [AW-1:0]     tgt_ext;
  logic [AW-1:0]     held_ext;
  logic [AW-1:0]     mag_c;
  logic [PW-1:0]     lim_c;
  logic [AW-1:0]     applied_c;
  logic [STEP_W:0]   rem_sh;
  logic              ge_c;
  logic [STEP_W:0]   rem_sub;
  logic [VW-1:0]     rlim_c;
  logic [VW-1:0]     next_c;
  logic [VW-1:0]     rate_c;
  logic              out_free;

  assign in_target = in_tdata[VW-1:0];
  assign in_step   = in_tdata[VW +: STEP_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    tgt_ext  = {tgt_r[VW-1], tgt_r};
    held_ext = {held_r[VW-1], held_r};
    up_c     = ($signed(tgt_r) >= $signed(held_r));
    mag_c    = up_c ? (tgt_ext - held_ext) : (held_ext - tgt_ext);
    lim_c    = prod_r >> FRAC_BITS;
    applied_c = (CW'(mag_r) < CW'(lim_c)) ? mag_r : AW'(lim_c);
    rem_sh   = {rem_r, div_r[QW-1]};
    ge_c     = (rem_sh >= {1'b0, dt_r});
    rem_sub  = rem_sh - {1'b0, dt_r};
    rlim_c   = up_r ? {1'b0, {(VW-1){1'b1}}} : {1'b1, {(VW-1){1'b0}}};
    next_c   = up_r ? (held_r + appl_r[VW-1:0]) : (held_r - appl_r[VW-1:0]);
    rate_c   = up_r ? div_r[VW-1:0] : (VW'(0) - div_r[VW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rising_r  <= '0;
      falling_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RISING:  rising_r  <= cfg_data;
        CFG_FALLING: falling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            tgt_r      <= in_target;
            dt_r       <= in_step;
            res_rate_r <= '0;
            priority if (in_tuser == REQ_RESET) begin
              held_r       <= in_target;
              init_r       <= 1'b1;
              res_status_r <= ST_OK;
              res_value_r  <= in_target;
              state_r      <= S_FIN;
            end else if (in_step == '0) begin
              res_status_r <= ST_RANGE;
              res_value_r  <= '0;
              state_r      <= S_FIN;
            end else if (!init_r) begin
              res_status_r <= ST_NOINIT;
              res_value_r  <= '0;
              state_r      <= S_FIN;
            end else begin
              res_status_r <= ST_OK;
              res_value_r  <= '0;
              state_r      <= S_MUL;
            end
          end
        end
        S_MUL: begin
          up_r    <= up_c;
          mag_r   <= mag_c;
          prod_r  <= (up_c ? rising_r : falling_r) * dt_r;
          state_r <= S_LIM;
        end
        S_LIM: begin
          appl_r  <= applied_c;
          div_r   <= {applied_c, {FRAC_BITS{1'b0}}};
          rem_r   <= '0;
          cnt_r   <= CNTW'(QW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge_c ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
          div_r <= {div_r[QW-2:0], ge_c};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (div_r > QW'(rlim_c)) begin
            res_status_r <= ST_RANGE;
          end else begin
            held_r      <= next_c;
            res_value_r <= next_c;
            res_rate_r  <= rate_c;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= OUT_W'({res_rate_r, res_value_r, res_status_r});
    end
  end

endmodule

// ===== src/asrl_chk.sv =====
// ----------------------------------------------------------------------------
// asrl_chk
// Port-level checks of the slew-rate limiter, bound to the core module.
// ----------------------------------------------------------------------------
module asrl_chk #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_W  = ((VALUE_WIDTH + asrl_pkg::STEP_W) + 7) / 8 * 8,
  localparam int OUT_W = ((2 + 2 * VALUE_WIDTH) + 7) / 8 * 8
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [IN_W-1:0]             in_tdata,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [OUT_W-1:0]            out_tdata,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input asrl_pkg::cfg_index_t        cfg_index,
  input logic [asrl_pkg::RATE_W-1:0] cfg_data
);
  import asrl_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int FB = FRAC_BITS;

  logic    unused_ok;
  status_t st;

  assign st        = out_tdata[1:0];
  assign unused_ok = ^{in_tdata, in_tuser, cfg_valid, cfg_ready, cfg_index, cfg_data, FB};

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |->
      out_tdata[2 +: VW] == '0 && out_tdata[2 + VW +: VW] == '0)
    else $error("error word carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> st == ST_OK || st == ST_RANGE || st == ST_NOINIT)
    else $error("bad status code");

endmodule

bind asymmetric_slew_rate_limiter_core asrl_chk #(
  .VALUE_WIDTH(VALUE_WIDTH),
  .FRAC_BITS(FRAC_BITS)
) u_asrl_chk (.*);
